// ===== rtl/lpl_pkg.sv =====
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared types and constants of the learned parameter link engine.
// ----------------------------------------------------------------------------
package lpl_pkg;

	localparam int TABLE_DEPTH_DEF = 256;
	localparam int ID_BITS_DEF     = 63;

	localparam logic [31:0] SETTLE_RESET = 32'd1000000;
	localparam logic signed [31:0] PRESS_LEVEL = 32'sd32768;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_LEARN  = 2'd1;
	localparam logic [1:0] OP_ACTIVE = 2'd2;
	localparam logic [1:0] OP_OBSERVE = 2'd3;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_LINKED = 2'd1;
	localparam logic [1:0] KIND_FAILED = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic        pressed;
		logic [19:0] dt;
		logic [31:0] sample;
	} cmd_t;

endpackage

// ===== rtl/learned_parameter_link_core.sv =====
// ----------------------------------------------------------------------------
// learned_parameter_link_core
// Learn-and-link engine: learns two parameters and forwards input to output.
// ----------------------------------------------------------------------------
// Ticks, switch presses, failed learn-offs and ids observed outside learning
// are handled in the idle state of the back end; an observed id walks the id
// table one entry a cycle, and a learn-off link passes through the LK1 and LK2
// states. A two-item queue sits ahead of the back end and busy is high only
// while it is full. Results come as a one-cycle result_valid strobe and cannot
// be held off.
module learned_parameter_link_core #(
	parameter int TABLE_DEPTH = lpl_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS     = lpl_pkg::ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               settle_us_we,
	input  logic [31:0]        settle_us_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [19:0]        time_step,
	input  logic signed [31:0] sample_value,
	input  logic [ID_BITS-1:0] event_param_id,
	output logic               result_valid,
	output logic [1:0]         result_kind,
	output logic [ID_BITS-1:0] target_id,
	output logic [ID_BITS-1:0] source_id,
	output logic signed [31:0] out_value
);

	logic [31:0]        settle_q;
	logic               q_valid, q_pop;
	lpl_pkg::cmd_t      q_cmd;
	logic [ID_BITS-1:0] q_id;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) settle_q <= lpl_pkg::SETTLE_RESET;
		else if (settle_us_we) settle_q <= settle_us_wdata;
	end

	lpl_front #(.ID_BITS(ID_BITS)) u_front (
		.clk, .arst_n, .start, .busy, .opcode, .time_step, .sample_value,
		.event_param_id, .q_valid, .q_pop, .q_cmd, .q_id
	);

	lpl_back #(.TABLE_DEPTH(TABLE_DEPTH), .ID_BITS(ID_BITS)) u_back (
		.clk, .arst_n, .settle_us(settle_q), .q_valid, .q_pop, .q_cmd, .q_id,
		.result_valid, .result_kind, .target_id, .source_id, .out_value
	);

endmodule

// ===== rtl/lpl_front.sv =====
// ----------------------------------------------------------------------------
// lpl_front
// Accepts items, decodes switch presses and queues them for the back end.
// ----------------------------------------------------------------------------
module lpl_front #(
	parameter int ID_BITS = lpl_pkg::ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [19:0]        time_step,
	input  logic signed [31:0] sample_value,
	input  logic [ID_BITS-1:0] event_param_id,
	output logic               q_valid,
	input  logic               q_pop,
	output lpl_pkg::cmd_t      q_cmd,
	output logic [ID_BITS-1:0] q_id
);

	lpl_pkg::cmd_t      cmd_q [2];
	logic [ID_BITS-1:0] id_q [2];
	logic               wr_q, rd_q;
	logic [1:0]         cnt_q;
	logic               push, pop;

	assign busy    = (cnt_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign pop     = q_pop && q_valid;
	assign q_cmd   = cmd_q[rd_q];
	assign q_id    = id_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_q].op      <= opcode;
			cmd_q[wr_q].pressed <= (sample_value >= lpl_pkg::PRESS_LEVEL);
			cmd_q[wr_q].dt      <= time_step;
			cmd_q[wr_q].sample  <= sample_value;
			id_q[wr_q]          <= event_param_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== rtl/lpl_back.sv =====
// ----------------------------------------------------------------------------
// lpl_back
// Executes queued items: table walk, settle tracking, linking, forwarding.
// ----------------------------------------------------------------------------
module lpl_back #(
	parameter int TABLE_DEPTH = lpl_pkg::TABLE_DEPTH_DEF,
	parameter int ID_BITS     = lpl_pkg::ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        settle_us,
	input  logic               q_valid,
	output logic               q_pop,
	input  lpl_pkg::cmd_t      q_cmd,
	input  logic [ID_BITS-1:0] q_id,
	output logic               result_valid,
	output logic [1:0]         result_kind,
	output logic [ID_BITS-1:0] target_id,
	output logic [ID_BITS-1:0] source_id,
	output logic signed [31:0] out_value
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LK1  = 2'd2;
	localparam logic [1:0] ST_LK2  = 2'd3;

	logic [ID_BITS-1:0] mem [TABLE_DEPTH];
	logic [ID_BITS-1:0] rdata_q;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;

	logic [1:0]         state_q;
	logic [CW-1:0]      total_q, settle_idx_q, scan_q, avail;
	logic               cmp_v_q;
	logic [ID_BITS-1:0] id_q, tgt_q;
	logic               learning_q, settled_q, active_q, linked_q, primed_q;
	logic [31:0]        learn_time_q, last_q;
	logic [32:0]        time_sum;
	logic [31:0]        time_new;
	logic               match;

	assign q_pop    = (state_q == ST_IDLE);
	assign time_sum = {1'b0, learn_time_q} + {13'd0, q_cmd.dt};
	assign time_new = time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
	assign match    = cmp_v_q && (rdata_q == id_q);
	assign avail    = total_q - settle_idx_q;
	assign wr_en    = (state_q == ST_SCAN) && !match && (scan_q == total_q)
		&& (total_q != CW'(TABLE_DEPTH));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_q[AW-1:0];
		if (state_q == ST_SCAN && !match && scan_q != total_q) begin
			rd_en = 1'b1;
		end else if (state_q == ST_IDLE) begin
			rd_en   = 1'b1;
			rd_addr = AW'(total_q - CW'(1));
		end else if (state_q == ST_LK1) begin
			rd_en   = 1'b1;
			rd_addr = AW'(total_q - CW'(2));
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= mem[rd_addr];
		if (wr_en) mem[total_q[AW-1:0]] <= id_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			total_q      <= '0;
			settle_idx_q <= '0;
			scan_q       <= '0;
			cmp_v_q      <= 1'b0;
			id_q         <= '0;
			tgt_q        <= '0;
			learning_q   <= 1'b0;
			settled_q    <= 1'b0;
			active_q     <= 1'b1;
			linked_q     <= 1'b0;
			primed_q     <= 1'b0;
			learn_time_q <= '0;
			last_q       <= '0;
			result_valid <= 1'b0;
			result_kind  <= lpl_pkg::KIND_WRITE;
			target_id    <= '0;
			source_id    <= '0;
			out_value    <= '0;
		end else begin
			result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						case (q_cmd.op)
							lpl_pkg::OP_TICK: begin
								if (learning_q) begin
									learn_time_q <= time_new;
									if (!settled_q && time_new >= settle_us) begin
										settled_q    <= 1'b1;
										settle_idx_q <= total_q;
									end
								end
								if (active_q && !learning_q && linked_q) begin
									if (!primed_q) begin
										primed_q <= 1'b1;
										last_q   <= q_cmd.sample;
									end else if (q_cmd.sample != last_q) begin
										last_q       <= q_cmd.sample;
										result_valid <= 1'b1;
										result_kind  <= lpl_pkg::KIND_WRITE;
										target_id    <= tgt_q;
										source_id    <= '0;
										out_value    <= q_cmd.sample;
									end
								end
							end
							lpl_pkg::OP_LEARN: begin
								if (q_cmd.pressed) begin
									if (!learning_q) begin
										learning_q   <= 1'b1;
										total_q      <= '0;
										learn_time_q <= '0;
										settled_q    <= 1'b0;
										linked_q     <= 1'b0;
										primed_q     <= 1'b0;
									end else begin
										learning_q <= 1'b0;
										if (settled_q && avail >= CW'(2)) begin
											state_q <= ST_LK1;
										end else begin
											result_valid <= 1'b1;
											result_kind  <= lpl_pkg::KIND_FAILED;
											target_id    <= '0;
											source_id    <= '0;
											out_value    <= '0;
										end
									end
								end
							end
							lpl_pkg::OP_ACTIVE: begin
								if (q_cmd.pressed) active_q <= !active_q;
							end
							default: begin
								if (learning_q) begin
									id_q    <= q_id;
									scan_q  <= '0;
									cmp_v_q <= 1'b0;
									state_q <= ST_SCAN;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (match) begin
						state_q <= ST_IDLE;
					end else if (scan_q == total_q) begin
						if (wr_en) total_q <= total_q + CW'(1);
						state_q <= ST_IDLE;
					end else begin
						scan_q  <= scan_q + CW'(1);
						cmp_v_q <= 1'b1;
					end
				end
				ST_LK1: begin
					tgt_q   <= rdata_q;
					state_q <= ST_LK2;
				end
				ST_LK2: begin
					linked_q     <= 1'b1;
					primed_q     <= 1'b0;
					result_valid <= 1'b1;
					result_kind  <= lpl_pkg::KIND_LINKED;
					target_id    <= tgt_q;
					source_id    <= rdata_q;
					out_value    <= '0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/lpl_checker.sv =====
// ----------------------------------------------------------------------------
// lpl_checker
// Port-level checks of result payloads for the link engine.
// ----------------------------------------------------------------------------
module lpl_checker #(
	parameter int ID_BITS = lpl_pkg::ID_BITS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic [1:0]         result_kind,
	input logic [ID_BITS-1:0] target_id,
	input logic [ID_BITS-1:0] source_id,
	input logic signed [31:0] out_value
);

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_kind == lpl_pkg::KIND_WRITE ||
		result_kind == lpl_pkg::KIND_LINKED || result_kind == lpl_pkg::KIND_FAILED))
		else $error("bad result kind");

	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == lpl_pkg::KIND_FAILED) |->
		(target_id == '0 && source_id == '0 && out_value == '0))
		else $error("failed link carries payload");

	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == lpl_pkg::KIND_WRITE) |-> (source_id == '0))
		else $error("write carries source");

	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == lpl_pkg::KIND_LINKED) |-> (out_value == '0))
		else $error("link carries value");

endmodule

bind learned_parameter_link_core lpl_checker #(.ID_BITS(ID_BITS)) u_lpl_checker (
	.clk, .arst_n, .result_valid, .result_kind, .target_id, .source_id, .out_value
);

// ===== tb/learned_parameter_link_core_tb.sv =====
// ----------------------------------------------------------------------------
// learned_parameter_link_core_tb
// Self-checking bench for the learn-and-link engine. A directed table runs
// first, then learn sessions with random content, noise and table fills.
// Each result is checked against a behavioral model of the engine or against
// a result pinned in the directed table.
`timescale 1ns / 1ps

module learned_parameter_link_core_tb;

	localparam int          DEPTH      = 256;
	localparam logic [1:0]  KIND_MODEL = 2'd3;
	localparam int          IDLE_LIMIT = 20000;
	localparam int          SETTLE_GAP = 1000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [62:0] tgt;
		logic [62:0] src;
		logic [31:0] val;
	} link_res_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [19:0] dt;
		logic [31:0] smp;
		logic [62:0] id;
		link_res_t   pin;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        settle_us_we = 1'b0;
	logic [31:0] settle_us_wdata = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  opcode = lpl_pkg::OP_TICK;
	logic [19:0] time_step = '0;
	logic signed [31:0] sample_value = '0;
	logic [62:0] event_param_id = '0;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [62:0] target_id;
	logic [62:0] source_id;
	logic signed [31:0] out_value;

	learned_parameter_link_core u_top (
		.clk(clk), .arst_n(arst_n),
		.settle_us_we(settle_us_we), .settle_us_wdata(settle_us_wdata),
		.start(start), .busy(busy), .opcode(opcode), .time_step(time_step),
		.sample_value(sample_value), .event_param_id(event_param_id),
		.result_valid(result_valid), .result_kind(result_kind),
		.target_id(target_id), .source_id(source_id), .out_value(out_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// engine model state
	logic [62:0] m_seen [DEPTH];
	bit          m_ign [DEPTH];
	int unsigned m_total;
	bit          m_learning, m_settled, m_active, m_linked, m_primed;
	logic [31:0] m_learn_time, m_settle;
	logic [62:0] m_src, m_tgt;
	logic [31:0] m_last;

	link_res_t   pending_results [$];
	int          mismatches = 0;
	int          idle_cycles = 0;
	dir_row_t    dir_rows [$];

	function automatic bit link_predict(input logic [1:0] op, input logic [19:0] dt,
			input logic [31:0] smp, input logic [62:0] id, output link_res_t r);
		bit pressed;
		bit have_new, have_old;
		int newest, older;
		logic [32:0] sum;
		pressed = $signed(smp) >= lpl_pkg::PRESS_LEVEL;
		r = '0;
		have_new = 0;
		have_old = 0;
		newest = 0;
		older = 0;
		case (op)
			lpl_pkg::OP_TICK: begin
				if (m_learning) begin
					sum = {1'b0, m_learn_time} + 33'(dt);
					m_learn_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if (!m_settled && m_learn_time >= m_settle) begin
						m_settled = 1;
						for (int i = 0; i < m_total; i++) m_ign[i] = 1;
					end
				end
				if (m_active && !m_learning && m_linked) begin
					if (!m_primed) begin
						m_primed = 1;
						m_last = smp;
					end else if (smp != m_last) begin
						m_last = smp;
						r = '{lpl_pkg::KIND_WRITE, m_tgt, 63'd0, smp};
						return 1;
					end
				end
				return 0;
			end
			lpl_pkg::OP_LEARN: begin
				if (!pressed) return 0;
				if (!m_learning) begin
					m_learning = 1;
					m_total = 0;
					m_learn_time = 0;
					m_settled = 0;
					m_linked = 0;
					m_primed = 0;
					return 0;
				end
				m_learning = 0;
				for (int i = int'(m_total) - 1; i >= 0; i--) begin
					if (!m_ign[i]) begin
						if (!have_new) begin
							newest = i;
							have_new = 1;
						end else if (!have_old) begin
							older = i;
							have_old = 1;
						end
					end
				end
				if (have_old) begin
					m_src = m_seen[older];
					m_tgt = m_seen[newest];
					m_linked = 1;
					m_primed = 0;
					r = '{lpl_pkg::KIND_LINKED, m_tgt, m_src, 32'd0};
				end else begin
					r = '{lpl_pkg::KIND_FAILED, 63'd0, 63'd0, 32'd0};
				end
				return 1;
			end
			lpl_pkg::OP_ACTIVE: begin
				if (pressed) m_active = !m_active;
				return 0;
			end
			default: begin
				if (!m_learning) return 0;
				for (int i = 0; i < m_total; i++)
					if (m_seen[i] == id) return 0;
				if (m_total >= DEPTH) return 0;
				m_seen[m_total] = id;
				m_ign[m_total] = !m_settled;
				m_total++;
				return 0;
			end
		endcase
	endfunction

	task automatic send(input logic [1:0] op, input logic [19:0] dt,
			input logic [31:0] smp, input logic [62:0] id, input link_res_t pin);
		link_res_t r;
		start <= 1'b1;
		opcode <= op;
		time_step <= dt;
		sample_value <= smp;
		event_param_id <= id;
		do @(posedge clk); while (busy);
		if (link_predict(op, dt, smp, id, r))
			pending_results.push_back(pin.kind == KIND_MODEL ? r : pin);
	endtask

	task automatic send_rand_gap(input logic [1:0] op, input logic [19:0] dt,
			input logic [31:0] smp, input logic [62:0] id);
		int r, n;
		send(op, dt, smp, id, '{KIND_MODEL, 63'd0, 63'd0, 32'd0});
		r = $urandom_range(0, 99);
		n = r < 60 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40));
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	task automatic write_settle(input logic [31:0] v);
		drain();
		settle_us_we <= 1'b1;
		settle_us_wdata <= v;
		@(posedge clk);
		settle_us_we <= 1'b0;
		m_settle = v;
	endtask

	function automatic logic [62:0] rand_id();
		return 63'({$urandom(), $urandom()});
	endfunction

	function automatic logic [19:0] rand_dt();
		return 20'($urandom());
	endfunction

	function automatic logic [31:0] press_val();
		return $urandom_range(0, 3) == 0 ? $urandom() : 32'h0001_0000;
	endfunction

	// one learn session with random content, then forwarding ticks
	task automatic session(input int n_obs, input int n_ticks);
		logic [62:0] pool [4];
		logic [31:0] vals [3];
		foreach (pool[i]) pool[i] = $urandom_range(0, 1) ? rand_id() : 63'($urandom_range(0, 9));
		foreach (vals[i]) vals[i] = $urandom();
		send_rand_gap(lpl_pkg::OP_LEARN, rand_dt(), 32'h0000_8000 + $urandom_range(0, 1000), 0);
		for (int i = 0; i < n_obs; i++) begin
			case ($urandom_range(0, 5))
				0, 1: send_rand_gap(lpl_pkg::OP_TICK, rand_dt(), $urandom(), rand_id());
				2: send_rand_gap(lpl_pkg::OP_OBSERVE, rand_dt(), $urandom(), rand_id());
				default: send_rand_gap(lpl_pkg::OP_OBSERVE, rand_dt(), $urandom(),
					pool[$urandom_range(0, 3)]);
			endcase
		end
		if ($urandom_range(0, 9) != 0)
			send_rand_gap(lpl_pkg::OP_LEARN, rand_dt(), press_val(), rand_id());
		for (int i = 0; i < n_ticks; i++) begin
			case ($urandom_range(0, 11))
				0: send_rand_gap(lpl_pkg::OP_ACTIVE, rand_dt(), press_val(), rand_id());
				1: send_rand_gap(lpl_pkg::OP_ACTIVE, rand_dt(), $urandom_range(0, 32767),
					rand_id());
				2: send_rand_gap(lpl_pkg::OP_LEARN, rand_dt(), $urandom_range(0, 32767),
					rand_id());
				3: send_rand_gap(lpl_pkg::OP_OBSERVE, rand_dt(), $urandom(), rand_id());
				4: send_rand_gap(lpl_pkg::OP_TICK, rand_dt(), $urandom(), rand_id());
				default: send_rand_gap(lpl_pkg::OP_TICK, rand_dt(), vals[$urandom_range(0, 2)],
					rand_id());
			endcase
		end
	endtask

	always @(posedge clk) begin
		link_res_t e;
		if (result_valid) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result kind %0d", result_kind);
			end else begin
				e = pending_results.pop_front();
				if (result_kind !== e.kind || target_id !== e.tgt || source_id !== e.src
						|| out_value !== e.val) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d %h %h %h got %0d %h %h %h", e.kind, e.tgt,
							e.src, e.val, result_kind, target_id, source_id, out_value);
				end
			end
		end
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic dir_row_t row(input logic [1:0] op, input logic [19:0] dt,
			input logic [31:0] smp, input logic [62:0] id, input link_res_t pin);
		return '{op, dt, smp, id, pin};
	endfunction

	initial begin
		link_res_t none;
		none = '{KIND_MODEL, 63'd0, 63'd0, 32'd0};
		m_total = 0;
		m_learning = 0;
		m_settled = 0;
		m_learn_time = 0;
		m_settle = lpl_pkg::SETTLE_RESET;
		m_active = 1;
		m_linked = 0;
		m_primed = 0;
		m_src = 0;
		m_tgt = 0;
		m_last = 0;
		foreach (m_seen[i]) begin
			m_seen[i] = 0;
			m_ign[i] = 0;
		end

		dir_rows.push_back(row(lpl_pkg::OP_TICK, 20'hFFFFF, 32'h7FFF_FFFF, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_ACTIVE, 0, 32'h0000_7FFF, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_LEARN, 0, 32'h0000_8000, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_OBSERVE, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF, none));
		dir_rows.push_back(row(lpl_pkg::OP_TICK, 20'hFFFFF, 0, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_OBSERVE, 20'hFFFFF, 32'hFFFF_FFFF, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_OBSERVE, 0, 0, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_OBSERVE, 0, 0, 63'd5, none));
		dir_rows.push_back(row(lpl_pkg::OP_LEARN, 0, 32'h7FFF_FFFF, 0,
			'{lpl_pkg::KIND_LINKED, 63'd5, 63'd0, 32'd0}));
		dir_rows.push_back(row(lpl_pkg::OP_TICK, 1, 32'd100, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_TICK, 1, 32'd100, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_TICK, 1, 32'h8000_0000, 0,
			'{lpl_pkg::KIND_WRITE, 63'd5, 63'd0, 32'h8000_0000}));
		dir_rows.push_back(row(lpl_pkg::OP_ACTIVE, 0, 32'h0000_8000, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_TICK, 0, 32'd1, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_ACTIVE, 0, 32'h0000_8000, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_TICK, 0, 32'd1, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_LEARN, 0, 32'h8000_0000, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_OBSERVE, 0, 0, 63'd9, none));
		dir_rows.push_back(row(lpl_pkg::OP_LEARN, 0, 32'h0000_8000, 0, none));
		dir_rows.push_back(row(lpl_pkg::OP_LEARN, 0, 32'h0000_8000, 0,
			'{lpl_pkg::KIND_FAILED, 63'd0, 63'd0, 32'd0}));
		dir_rows.push_back(row(lpl_pkg::OP_TICK, 0, 32'd7, 0, none));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send(dir_rows[i].op, dir_rows[i].dt, dir_rows[i].smp, dir_rows[i].id,
				dir_rows[i].pin);
			if (i % 3 == 2) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end

		// settle at once: everything is usable, fill the table past full
		write_settle(32'd0);
		send_rand_gap(lpl_pkg::OP_LEARN, 0, 32'h0001_0000, 0);
		send_rand_gap(lpl_pkg::OP_TICK, 0, 0, 0);
		for (int i = 0; i < 300; i++) send_rand_gap(lpl_pkg::OP_OBSERVE, 0, 0, rand_id());
		send_rand_gap(lpl_pkg::OP_LEARN, 0, 32'h0001_0000, 0);
		for (int i = 0; i < 10; i++) session(12, 20);

		// never settles
		write_settle(32'hFFFF_FFFF);
		send_rand_gap(lpl_pkg::OP_LEARN, 0, 32'h0001_0000, 0);
		send_rand_gap(lpl_pkg::OP_OBSERVE, 0, 0, 63'd1);
		send_rand_gap(lpl_pkg::OP_OBSERVE, 0, 0, 63'd2);
		for (int i = 0; i < 40; i++) begin
			send(lpl_pkg::OP_TICK, 20'hFFFFF, 0, 0, none);
		end
		send_rand_gap(lpl_pkg::OP_OBSERVE, 0, 0, 63'd3);
		send_rand_gap(lpl_pkg::OP_OBSERVE, 0, 0, 63'd4);
		send_rand_gap(lpl_pkg::OP_LEARN, 0, 32'h0001_0000, 0);
		for (int i = 0; i < 5; i++) session(12, 20);

		write_settle(lpl_pkg::SETTLE_RESET);
		for (int i = 0; i < 5; i++) session(12, 20);

		for (int p = 0; p < 3; p++) begin
			write_settle(p == 0 ? 32'd1 : $urandom_range(0, 3000000));
			for (int i = 0; i < 10; i++) begin
				session($urandom_range(2, 16), $urandom_range(4, 24));
				if (i == 4) drain();
			end
		end

		drain();
		if (pending_results.size() != 0) mismatches++;
		if (mismatches == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lpl_pkg.sv
rtl/lpl_front.sv
rtl/lpl_back.sv
rtl/learned_parameter_link_core.sv
rtl/lpl_checker.sv
tb/learned_parameter_link_core_tb.sv
